// ===== rtl/core/sfr_pkg.sv =====
// package of constants and types for the sbus frame receiver
`timescale 1ns / 1ps
package sfr_pkg;

  // frame layout
  localparam int unsigned FrameBytes   = 25;
  localparam int unsigned FlagByte     = 23;
  localparam int unsigned LastDataByte = 22;
  localparam int unsigned EndByte      = FrameBytes - 1;
  localparam logic [7:0]  HeaderByte   = 8'h0F;

  // channel layout
  localparam int unsigned NumChannels = 16;
  localparam int unsigned ChanBits    = 11;
  localparam int unsigned FlagBits    = 4;

  // widths of internal counters and buses
  localparam int unsigned CountW   = 5;
  localparam int unsigned ChanIdxW = 4;
  localparam int unsigned BankW    = 1;
  localparam int unsigned AddrW    = BankW + CountW;
  localparam int unsigned MemDepth = 1 << AddrW;
  localparam int unsigned BitBufW  = ChanBits - 1 + 8;
  localparam int unsigned OutDataW = 24;

  // one result as held in the output register
  typedef struct packed {
    logic                safe_flag;
    logic                lost_flag;
    logic                switch_two;
    logic                switch_one;
    logic [ChanBits-1:0] channel_value;
    logic [ChanIdxW-1:0] channel_index;
  } result_t;

endpackage

// ===== rtl/core/sbus_frame_receiver_unit.sv =====
// sbus frame receiver: byte hunt, ping-pong frame memory and channel unpacker
// First channel after end byte: bank full flag, read data, bit buffer, output register.
// Throughput: one byte per cycle in while a bank is free; the unpacker reads at most one
// stored byte per cycle and gives the 16 channels of a frame while output is not stalled.
// Input stalls only while both frame banks hold frames that are still being unpacked.
// Reset (rst_ni low, asynchronous) returns to header hunt with both banks empty.
`timescale 1ns / 1ps
module sbus_frame_receiver_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input bytes
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // rx_byte [7:0]
  // channel results
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // channel_index [3:0], channel_value [14:4], switch_one [15], switch_two [16],
  // lost_flag [17], safe_flag [18], zero fill [23:19]
  output logic [sfr_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o   // last_channel
);

  localparam int unsigned CountW  = sfr_pkg::CountW;
  localparam int unsigned AddrW   = sfr_pkg::AddrW;
  localparam int unsigned BitBufW = sfr_pkg::BitBufW;
  localparam int unsigned ResW    = $bits(sfr_pkg::result_t);

  // frame memory, one bank per frame
  logic [7:0] mem_q [sfr_pkg::MemDepth];

  // byte hunt and frame writer state
  logic              in_frame_q, in_frame_d;
  logic [CountW-1:0] count_q, count_d;
  logic              wr_bank_q, wr_bank_d;
  logic [1:0]        full_q, full_d;
  logic [sfr_pkg::FlagBits-1:0] flags_q [2];

  // unpacker state
  logic                       rd_bank_q, rd_bank_d;
  logic [CountW-1:0]          rd_idx_q, rd_idx_d;
  logic                       rd_pend_q;
  logic [7:0]                 rd_data_q;
  logic [BitBufW-1:0]         buf_q, buf_d, base_buf;
  logic [CountW-1:0]          cnt_q, cnt_d, base_cnt;
  logic [sfr_pkg::ChanIdxW-1:0] ch_q, ch_d;

  // output register
  logic              out_valid_q, out_valid_d;
  sfr_pkg::result_t  res_q;
  logic              last_q;

  logic in_req, mem_we, frame_good, flag_we;
  logic drain_act, slot_free, emit, last_emit, rd_issue;

  // writer side
  assign s_axis_tready_o = !full_q[wr_bank_q];
  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;
  assign mem_we  = in_req && in_frame_q && (count_q <= CountW'(sfr_pkg::LastDataByte));
  assign flag_we = in_req && in_frame_q && (count_q == CountW'(sfr_pkg::FlagByte));
  assign frame_good = in_req && in_frame_q && (count_q == CountW'(sfr_pkg::EndByte))
                      && (s_axis_tdata_i == 8'h00);

  // hunt and byte count
  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    wr_bank_d  = wr_bank_q;
    if (in_req) begin
      if (!in_frame_q) begin
        if (s_axis_tdata_i == sfr_pkg::HeaderByte) begin
          in_frame_d = 1'b1;
          count_d    = CountW'(1);
        end
      end else if (count_q == CountW'(sfr_pkg::EndByte)) begin
        in_frame_d = 1'b0;
        count_d    = '0;
        if (frame_good) begin
          wr_bank_d = !wr_bank_q;
        end
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  // bank occupancy
  always_comb begin
    full_d = full_q;
    if (last_emit) begin
      full_d[rd_bank_q] = 1'b0;
    end
    if (frame_good) begin
      full_d[wr_bank_q] = 1'b1;
    end
  end

  // unpacker: bit buffer fed at most one byte a cycle, drained eleven bits a result
  assign drain_act = full_q[rd_bank_q];
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign emit      = drain_act && (cnt_q >= CountW'(sfr_pkg::ChanBits)) && slot_free;
  assign last_emit = emit && (ch_q == sfr_pkg::ChanIdxW'(sfr_pkg::NumChannels - 1));

  always_comb begin
    base_cnt  = emit ? cnt_q - CountW'(sfr_pkg::ChanBits) : cnt_q;
    base_buf  = emit ? buf_q >> sfr_pkg::ChanBits : buf_q;
    buf_d     = base_buf;
    cnt_d     = base_cnt;
    ch_d      = emit ? ch_q + sfr_pkg::ChanIdxW'(1) : ch_q;
    rd_bank_d = rd_bank_q;
    rd_idx_d  = rd_idx_q;
    if (rd_pend_q) begin
      buf_d = base_buf | (BitBufW'(rd_data_q) << base_cnt);
      cnt_d = base_cnt + CountW'(8);
    end
    rd_issue = drain_act && !last_emit
               && (rd_idx_q <= CountW'(sfr_pkg::LastDataByte))
               && (cnt_d <= CountW'(sfr_pkg::ChanBits - 1));
    if (rd_issue) begin
      rd_idx_d = rd_idx_q + CountW'(1);
    end
    if (last_emit) begin
      buf_d     = '0;
      cnt_d     = '0;
      ch_d      = '0;
      rd_idx_d  = CountW'(1);
      rd_bank_d = !rd_bank_q;
    end
  end

  assign out_valid_d = emit || (out_valid_q && !m_axis_tready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      wr_bank_q   <= 1'b0;
      full_q      <= '0;
      rd_bank_q   <= 1'b0;
      rd_idx_q    <= CountW'(1);
      rd_pend_q   <= 1'b0;
      buf_q       <= '0;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      count_q     <= count_d;
      wr_bank_q   <= wr_bank_d;
      full_q      <= full_d;
      rd_bank_q   <= rd_bank_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_issue;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // frame memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[{wr_bank_q, count_q}] <= s_axis_tdata_i;
    end
    if (rd_issue) begin
      rd_data_q <= mem_q[{rd_bank_q, rd_idx_q}];
    end
  end

  // flag byte per bank
  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flags_q[wr_bank_q] <= s_axis_tdata_i[sfr_pkg::FlagBits-1:0];
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q.channel_index <= ch_q;
      res_q.channel_value <= buf_q[sfr_pkg::ChanBits-1:0];
      res_q.switch_one    <= flags_q[rd_bank_q][0];
      res_q.switch_two    <= flags_q[rd_bank_q][1];
      res_q.lost_flag     <= flags_q[rd_bank_q][2];
      res_q.safe_flag     <= flags_q[rd_bank_q][3];
      last_q              <= last_emit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(sfr_pkg::OutDataW - ResW)'(0), res_q};
  assign m_axis_tlast_o  = last_q;

  // checks
  a_no_write_full_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !full_q[wr_bank_q])
    else $error("write into a bank that is still being unpacked");

  a_bitbuf_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(BitBufW))
    else $error("bit buffer overfilled");

  a_frame_fully_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_emit |-> (!rd_pend_q && rd_idx_q == CountW'(sfr_pkg::LastDataByte + 1)))
    else $error("frame finished before all bytes were read");

  a_read_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> (full_q[rd_bank_q] && !(mem_we && wr_bank_q == rd_bank_q)))
    else $error("read from a bank that is being written");

endmodule
